FILE: design/hsm_pkg.sv
// ---------------------------------------------------------------------------
// hsm_pkg
// Shared types and constants of the hard-sphere move checker.
// ---------------------------------------------------------------------------
`default_nettype none

package hsm_pkg;

    localparam int MAX_PARTICLES = 128;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int COORD_W       = 16;
    localparam int CENTRE_W      = 3 * COORD_W;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;

    // Item opcodes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_PROPOSE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Register indexes (byte address is four times the index)
    localparam logic [2:0] REG_BOX_X   = 3'd0;
    localparam logic [2:0] REG_BOX_Y   = 3'd1;
    localparam logic [2:0] REG_BOX_Z   = 3'd2;
    localparam logic [2:0] REG_CONTACT = 3'd3;
    localparam logic [2:0] REG_STEP    = 3'd4;
    localparam logic [2:0] REG_ACTIVE  = 3'd5;

    // Operand selection of the shared multiplier
    typedef enum logic {
        ALU_STEP   = 1'b0,
        ALU_SQUARE = 1'b1
    } t_alu_mode;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [6:0]         particle;
        logic [15:0]        load_x;
        logic [15:0]        load_y;
        logic [15:0]        load_z;
        logic signed [15:0] frac_x;
        logic signed [15:0] frac_y;
        logic signed [15:0] frac_z;
        logic               sweep_end;
    } t_in_beat;

    typedef struct packed {
        logic        accepted;
        logic [15:0] centre_x;
        logic [15:0] centre_y;
        logic [15:0] centre_z;
        logic [7:0]  sweep_accepts;
    } t_out_beat;

endpackage

`default_nettype wire

FILE: design/hsm_in_if.sv
// ---------------------------------------------------------------------------
// hsm_in_if / hsm_out_if
// Valid/ready channels carrying input items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface hsm_in_if;
    logic              valid;
    logic              ready;
    hsm_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hsm_out_if;
    logic               valid;
    logic               ready;
    hsm_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/hsm_ram.sv
// ---------------------------------------------------------------------------
// hsm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hsm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: design/hsm_alu.sv
// ---------------------------------------------------------------------------
// hsm_alu
// Shared arithmetic unit: one multiplier for step scaling and squaring, the
// periodic wrap of a moved coordinate and the minimum-image distance.
// ---------------------------------------------------------------------------
`default_nettype none

module hsm_alu (
    input  wire hsm_pkg::t_alu_mode i_mode,
    input  wire logic signed [15:0] i_frac,
    input  wire logic [14:0]        i_max_step,
    input  wire logic [15:0]        i_mag,
    input  wire logic [15:0]        i_coord,
    input  wire logic signed [16:0] i_step,
    input  wire logic [15:0]        i_other,
    input  wire logic [15:0]        i_len,
    output logic signed [16:0]      o_step,
    output logic [31:0]             o_sq,
    output logic [15:0]             o_wrap,
    output logic [15:0]             o_image
);

    logic signed [16:0] s_mul_a;
    logic signed [16:0] s_mul_b;
    logic signed [33:0] s_prod;
    logic signed [33:0] s_round;
    logic signed [17:0] s_sum;
    logic signed [17:0] s_len18;
    logic signed [17:0] s_wrapped;
    logic signed [16:0] s_diff;
    logic [16:0]        s_absd;
    logic signed [16:0] s_mirror;

    // Shared multiplier: fraction times step limit, or a distance squared.
    always_comb begin
        if (i_mode == hsm_pkg::ALU_STEP) begin
            s_mul_a = {i_frac[15], i_frac};
            s_mul_b = {2'b00, i_max_step};
        end else begin
            s_mul_a = {1'b0, i_mag};
            s_mul_b = {1'b0, i_mag};
        end
        s_prod  = s_mul_a * s_mul_b;
        s_round = s_prod + 34'sd16384;
    end

    // Round to nearest, ties upwards, by an arithmetic shift.
    assign o_step = s_round[31:15];
    assign o_sq   = s_prod[31:0];

    // Wrap once into the box, then keep the low sixteen bits.
    always_comb begin
        s_sum   = $signed({2'b00, i_coord}) + $signed({i_step[16], i_step});
        s_len18 = $signed({2'b00, i_len});
        if (s_sum >= s_len18) begin
            s_wrapped = s_sum - s_len18;
        end else if (s_sum < 18'sd0) begin
            s_wrapped = s_sum + s_len18;
        end else begin
            s_wrapped = s_sum;
        end
        o_wrap = s_wrapped[15:0];
    end

    // Minimum-image separation magnitude along one axis.
    always_comb begin
        s_diff   = $signed({1'b0, i_coord}) - $signed({1'b0, i_other});
        s_absd   = s_diff[16] ? 17'(-s_diff) : 17'(s_diff);
        s_mirror = $signed({1'b0, i_len}) - $signed(s_absd);
        if ({s_absd, 1'b0} > {2'b00, i_len}) begin
            o_image = s_mirror[16] ? 16'(-s_mirror) : s_mirror[15:0];
        end else begin
            o_image = s_absd[15:0];
        end
    end

endmodule

`default_nettype wire

FILE: design/hard_sphere_move_checker_unit.sv
// ---------------------------------------------------------------------------
// hard_sphere_move_checker_unit
// Hard-sphere Monte Carlo move checker in a periodic box.
//
// Items enter on i_in (valid/ready); every item gives exactly one result
// beat on o_out. A load beat writes a centre, a read beat returns one. A
// propose beat scales the three fractions, wraps the new centre and tests
// it against every other active particle, one particle at a time through
// the shared multiplier; the particles tested are active_count capped at
// 128. With sweep_end set, a commit pass copies pending centres into
// the centre memory, one entry at a time over the single write port, and
// reports the sweep's accept count. The block takes one item at a time;
// i_in.ready is high only when idle. Results sit in an output register, so
// a new item is taken while a result waits; a stalled receiver only holds
// the block when a second result is ready. Reset restores the register
// defaults and clears the pending flags, the accept count and the output
// valid; centre memories hold nothing until loaded. Registers must be
// written over APB only while idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

module hard_sphere_move_checker_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    hsm_in_if.sink                             i_in,
    hsm_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hsm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [hsm_pkg::PDATA_W-1:0]   pwdata,
    output logic      [hsm_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int IW = hsm_pkg::IDX_W;
    localparam int CW = hsm_pkg::CNT_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_RD     = 11'b00000000010,
        S_OWN    = 11'b00000000100,
        S_MUL    = 11'b00000001000,
        S_WRAP   = 11'b00000010000,
        S_FETCH  = 11'b00000100000,
        S_AXIS   = 11'b00001000000,
        S_LAST   = 11'b00010000000,
        S_DECIDE = 11'b00100000000,
        S_CRD    = 11'b01000000000,
        S_CWR    = 11'b10000000000
    } t_state;

    // Configuration registers
    logic [15:0] r_box_x, r_box_y, r_box_z;
    logic [31:0] r_contact;
    logic [14:0] r_max_step;
    logic [7:0]  r_active;

    // Control and datapath registers
    t_state                        r_state,  n_state;
    logic [1:0]                    r_ax,     n_ax;
    logic [CW-1:0]                 r_k,      n_k;
    logic                          r_ok,     n_ok;
    logic                          r_pend,   n_pend;
    hsm_pkg::t_in_beat             r_item,   n_item;
    logic [hsm_pkg::CENTRE_W-1:0]  r_own,    n_own;
    logic signed [16:0]            r_step,   n_step;
    logic [hsm_pkg::CENTRE_W-1:0]  r_new,    n_new;
    logic [15:0]                   r_d,      n_d;
    logic [33:0]                   r_acc,    n_acc;
    logic [7:0]                    r_cnt,    n_cnt;
    logic [hsm_pkg::MAX_PARTICLES-1:0] r_pv, n_pv;
    hsm_pkg::t_out_beat            r_res,    n_res;
    logic                          r_ovalid, n_ovalid;
    hsm_pkg::t_out_beat            r_odata,  n_odata;

    // Memory ports
    logic                          c_we, p_we;
    logic [IW-1:0]                 c_waddr, c_raddr;
    logic [hsm_pkg::CENTRE_W-1:0]  c_wdata, c_rdata, p_rdata;

    // Shared unit connections
    hsm_pkg::t_alu_mode            alu_mode;
    logic signed [15:0]            alu_frac;
    logic [15:0]                   alu_coord, alu_other, alu_len;
    logic signed [16:0]            alu_step;
    logic [31:0]                   alu_sq;
    logic [15:0]                   alu_wrap, alu_image;

    logic [CW-1:0]                 s_n;
    logic [33:0]                   s_total;
    logic                          s_accept, s_out_free;
    logic                          s_cfg_wr;

    // ---------------- configuration port ----------------

    assign pready   = 1'b1;
    assign s_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x    <= 16'd1280;
            r_box_y    <= 16'd1280;
            r_box_z    <= 16'd1280;
            r_contact  <= 32'd65536;
            r_max_step <= 15'd51;
            r_active   <= 8'd80;
        end else if (s_cfg_wr) begin
            case (paddr[4:2])
                hsm_pkg::REG_BOX_X:   r_box_x    <= pwdata[15:0];
                hsm_pkg::REG_BOX_Y:   r_box_y    <= pwdata[15:0];
                hsm_pkg::REG_BOX_Z:   r_box_z    <= pwdata[15:0];
                hsm_pkg::REG_CONTACT: r_contact  <= pwdata;
                hsm_pkg::REG_STEP:    r_max_step <= pwdata[14:0];
                hsm_pkg::REG_ACTIVE:  r_active   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            hsm_pkg::REG_BOX_X:   prdata = {16'd0, r_box_x};
            hsm_pkg::REG_BOX_Y:   prdata = {16'd0, r_box_y};
            hsm_pkg::REG_BOX_Z:   prdata = {16'd0, r_box_z};
            hsm_pkg::REG_CONTACT: prdata = r_contact;
            hsm_pkg::REG_STEP:    prdata = {17'd0, r_max_step};
            hsm_pkg::REG_ACTIVE:  prdata = {24'd0, r_active};
            default:              prdata = '0;
        endcase
    end

    // ---------------- memories and shared unit ----------------

    hsm_ram #(
        .WIDTH(hsm_pkg::CENTRE_W),
        .DEPTH(hsm_pkg::MAX_PARTICLES)
    ) u_centres (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    hsm_ram #(
        .WIDTH(hsm_pkg::CENTRE_W),
        .DEPTH(hsm_pkg::MAX_PARTICLES)
    ) u_pending (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_item.particle[IW-1:0]),
        .i_wdata (r_new),
        .i_raddr (r_k[IW-1:0]),
        .o_rdata (p_rdata)
    );

    hsm_alu u_alu (
        .i_mode     (alu_mode),
        .i_frac     (alu_frac),
        .i_max_step (r_max_step),
        .i_mag      (r_d),
        .i_coord    (alu_coord),
        .i_step     (r_step),
        .i_other    (alu_other),
        .i_len      (alu_len),
        .o_step     (alu_step),
        .o_sq       (alu_sq),
        .o_wrap     (alu_wrap),
        .o_image    (alu_image)
    );

    // Axis operand selection for the shared unit.
    always_comb begin
        case (r_ax)
            2'd0:    begin alu_frac = r_item.frac_x; alu_len = r_box_x; end
            2'd1:    begin alu_frac = r_item.frac_y; alu_len = r_box_y; end
            default: begin alu_frac = r_item.frac_z; alu_len = r_box_z; end
        endcase
        alu_mode  = (r_state == S_MUL) ? hsm_pkg::ALU_STEP : hsm_pkg::ALU_SQUARE;
        alu_coord = (r_state == S_WRAP) ? r_own[16*r_ax +: 16] : r_new[16*r_ax +: 16];
        alu_other = c_rdata[16*r_ax +: 16];
    end

    // ---------------- sequencer ----------------

    assign s_n        = (r_active > 8'(hsm_pkg::MAX_PARTICLES))
                        ? CW'(hsm_pkg::MAX_PARTICLES) : CW'(r_active);
    assign s_total    = r_acc + {2'b00, alu_sq};
    assign s_out_free = !r_ovalid || o_out.ready;
    assign s_accept   = i_in.valid && i_in.ready;

    // Idle, and no finished result is stuck behind a full output register.
    assign i_in.ready  = (r_state == S_IDLE) && !(r_pend && !s_out_free);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    always_comb begin
        n_state  = r_state;
        n_ax     = r_ax;
        n_k      = r_k;
        n_ok     = r_ok;
        n_pend   = r_pend;
        n_item   = r_item;
        n_own    = r_own;
        n_step   = r_step;
        n_new    = r_new;
        n_d      = r_d;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_pv     = r_pv;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        c_we     = 1'b0;
        c_waddr  = r_item.particle[IW-1:0];
        c_wdata  = c_rdata;
        c_raddr  = r_item.particle[IW-1:0];
        p_we     = 1'b0;

        // A delivered beat frees the output register.
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        // A finished result moves to the output register when it is free.
        if (r_pend && s_out_free) begin
            n_ovalid = 1'b1;
            n_odata  = r_res;
            n_pend   = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                c_raddr = i_in.data.particle[IW-1:0];
                if (s_accept && !(r_pend && !s_out_free)) begin
                    n_item = i_in.data;
                    n_res  = '0;
                    n_ax   = 2'd0;
                    case (i_in.data.opcode)
                        hsm_pkg::OP_LOAD: begin
                            c_we    = 1'b1;
                            c_waddr = i_in.data.particle[IW-1:0];
                            c_wdata = {i_in.data.load_z, i_in.data.load_y,
                                       i_in.data.load_x};
                            n_res.centre_x = i_in.data.load_x;
                            n_res.centre_y = i_in.data.load_y;
                            n_res.centre_z = i_in.data.load_z;
                            n_pend  = 1'b1;
                        end
                        hsm_pkg::OP_READ:    n_state = S_RD;
                        hsm_pkg::OP_PROPOSE: n_state = S_OWN;
                        default:             n_pend  = 1'b1;
                    endcase
                end
            end
            S_RD: begin
                n_res.centre_x = c_rdata[15:0];
                n_res.centre_y = c_rdata[31:16];
                n_res.centre_z = c_rdata[47:32];
                n_pend  = 1'b1;
                n_state = S_IDLE;
            end
            S_OWN: begin
                n_own   = c_rdata;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_step  = alu_step;
                n_state = S_WRAP;
            end
            S_WRAP: begin
                n_new[16*r_ax +: 16] = alu_wrap;
                if (r_ax == 2'd2) begin
                    n_k     = '0;
                    n_ok    = 1'b1;
                    n_state = (s_n == '0) ? S_DECIDE : S_FETCH;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_FETCH: begin
                c_raddr = r_k[IW-1:0];
                n_ax    = 2'd0;
                n_state = S_AXIS;
            end
            S_AXIS: begin
                // Square of the previous axis accumulates while this one is found.
                c_raddr = r_k[IW-1:0];
                n_d     = alu_image;
                n_acc   = (r_ax == 2'd0) ? '0 : s_total;
                if (r_ax == 2'd2) begin
                    n_state = S_LAST;
                end else begin
                    n_ax = r_ax + 2'd1;
                end
            end
            S_LAST: begin
                c_raddr = r_k[IW-1:0];
                if ((s_total <= {2'b00, r_contact}) &&
                    (r_k[IW-1:0] != r_item.particle[IW-1:0])) begin
                    n_ok = 1'b0;
                end
                n_ax = 2'd0;
                if ((r_k + CW'(1)) >= s_n) begin
                    n_state = S_DECIDE;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_FETCH;
                end
            end
            S_DECIDE: begin
                n_pv[r_item.particle[IW-1:0]] = r_ok;
                p_we           = r_ok;
                n_res.accepted = r_ok;
                n_res.centre_x = r_new[15:0];
                n_res.centre_y = r_new[31:16];
                n_res.centre_z = r_new[47:32];
                if (r_ok && (r_cnt != 8'hFF)) begin
                    n_cnt = r_cnt + 8'd1;
                end
                if (r_item.sweep_end) begin
                    n_k     = '0;
                    n_state = S_CRD;
                end else begin
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CRD: begin
                n_state = S_CWR;
            end
            S_CWR: begin
                // Commit the pending centre of entry r_k, if it has one.
                c_we    = r_pv[r_k[IW-1:0]];
                c_waddr = r_k[IW-1:0];
                c_wdata = p_rdata;
                n_pv[r_k[IW-1:0]] = 1'b0;
                if (r_k == CW'(hsm_pkg::MAX_PARTICLES - 1)) begin
                    n_res.sweep_accepts = r_cnt;
                    n_cnt   = '0;
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_CRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_cnt    <= '0;
            r_pv     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_cnt    <= n_cnt;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        r_ax    <= n_ax;
        r_k     <= n_k;
        r_ok    <= n_ok;
        r_item  <= n_item;
        r_own   <= n_own;
        r_step  <= n_step;
        r_new   <= n_new;
        r_d     <= n_d;
        r_acc   <= n_acc;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

endmodule

`default_nettype wire
